// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the parser core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low asynchronous reset.
`define ABP_ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Shorthand on the block's own clock and reset.
`define ABP_ASSERT(lbl, prop, msg) \
	`ABP_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

// ----- rtl/abp_pkg.sv -----
package abp_pkg;

	// build limits
	localparam logic [7:0] LINE_LIMIT    = 8'd8;
	localparam logic [7:0] DIR_LIMIT     = 8'd4;
	localparam logic [7:0] ARRIVAL_LIMIT = 8'd8;

	// record layout
	localparam logic [6:0] MIN_RECORD  = 7'd56;
	localparam logic [6:0] BYTE_SAT    = 7'd127;
	localparam logic [6:0] EPOCH_LEN   = 7'd4;
	localparam logic [6:0] STATION_LEN = 7'd39;
	localparam logic [6:0] ID_SHORT    = 7'd11;
	localparam logic [6:0] ID_LONG     = 7'd39;
	localparam logic [6:0] LABEL_LEN   = 7'd2;
	localparam logic [6:0] DEST_LEN    = 7'd20;
	localparam logic [6:0] DLABEL_LEN  = 7'd10;
	localparam logic [7:0] NOTICE_MAX  = 8'd80;
	localparam logic [7:0] LEGACY_MAX  = 8'd4;
	localparam logic [7:0] VER_MIN     = 8'd3;
	localparam logic [7:0] VER_MAX     = 8'd8;

	// version thresholds for optional fields
	localparam logic [3:0] VER_NOTICE  = 4'd4;
	localparam logic [3:0] VER_EXPRESS = 4'd5;
	localparam logic [3:0] VER_DLABEL  = 4'd6;
	localparam logic [3:0] VER_SCHED   = 4'd7;
	localparam logic [3:0] VER_LONG_ID = 4'd8;

	// parser phases, also the field kind codes
	localparam logic [4:0] PH_VER     = 5'd0;
	localparam logic [4:0] PH_EPOCH   = 5'd1;
	localparam logic [4:0] PH_STATION = 5'd2;
	localparam logic [4:0] PH_ID      = 5'd3;
	localparam logic [4:0] PH_NLINES  = 5'd4;
	localparam logic [4:0] PH_LABEL   = 5'd5;
	localparam logic [4:0] PH_RED     = 5'd6;
	localparam logic [4:0] PH_GREEN   = 5'd7;
	localparam logic [4:0] PH_BLUE    = 5'd8;
	localparam logic [4:0] PH_NDIRS   = 5'd9;
	localparam logic [4:0] PH_SCHED   = 5'd10;
	localparam logic [4:0] PH_NLEN    = 5'd11;
	localparam logic [4:0] PH_NOTICE  = 5'd12;
	localparam logic [4:0] PH_DEST    = 5'd13;
	localparam logic [4:0] PH_DLABEL  = 5'd14;
	localparam logic [4:0] PH_LEGACY  = 5'd15;
	localparam logic [4:0] PH_NARR    = 5'd16;
	localparam logic [4:0] PH_DELTA   = 5'd17;
	localparam logic [4:0] PH_EXP     = 5'd18;
	localparam logic [4:0] PH_DONE    = 5'd19;
	localparam logic [4:0] PH_REJECT  = 5'd20;

	// record status
	localparam logic [1:0] ST_PARSING = 2'd0;
	localparam logic [1:0] ST_ACCEPT  = 2'd1;
	localparam logic [1:0] ST_REJECT  = 2'd2;

	typedef struct packed {
		logic [4:0]  phase;
		logic [3:0]  record_version;
		logic [6:0]  byte_total;
		logic [6:0]  field_position;
		logic [6:0]  field_length;
		logic [3:0]  line_count;
		logic [3:0]  line_total;
		logic [2:0]  dir_count;
		logic [2:0]  dir_total;
		logic [3:0]  arrival_count;
		logic [3:0]  arrival_total;
		logic [31:0] value_accumulator;
		logic [1:0]  outcome;
	} abp_state_t;

	typedef struct packed {
		logic [4:0]  field_kind;
		logic [31:0] field_value;
		logic        value_valid;
		logic [2:0]  line_index;
		logic [1:0]  dir_index;
		logic [6:0]  item_index;
		logic [1:0]  status;
		logic        final_res;
	} abp_res_t;

endpackage

// ----- rtl/abp_in_if.sv -----
interface abp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_record;

	modport source (output valid, output data_byte, output end_of_record, input ready);
	modport sink (input valid, input data_byte, input end_of_record, output ready);
endinterface

// ----- rtl/abp_res_if.sv -----
interface abp_res_if;
	logic        valid;
	logic        ready;
	logic [4:0]  field_kind;
	logic [31:0] field_value;
	logic        value_valid;
	logic [2:0]  line_index;
	logic [1:0]  dir_index;
	logic [6:0]  item_index;
	logic [1:0]  status;
	logic        final_res;

	modport source (
		output valid, output field_kind, output field_value, output value_valid,
		output line_index, output dir_index, output item_index, output status,
		output final_res, input ready
	);
	modport sink (
		input valid, input field_kind, input field_value, input value_valid,
		input line_index, input dir_index, input item_index, input status,
		input final_res, output ready
	);
endinterface

// ----- rtl/arrival_bundle_parser_core.sv -----
// Channel  Role    Transaction payload
// -------  ------  -------------------------------------------------------------
// stream   sink    data_byte, end_of_record: one record byte
// result   source  kind, value, value_valid, indexes, status, final_res of a byte
//
// One byte per cycle sustained while result is ready: the parse state advances once per byte.
// A byte's tag reaches result through the input register, then the result register.
// arst_n clears the parse state and both stage valid flags; no clearing pass.
// A stall on result holds the result register; the input register takes one more
// byte only if it is empty, then stream.ready drops until result drains.
`include "assert_macros.svh"

module arrival_bundle_parser_core (
	input logic      clk,
	input logic      arst_n,
	abp_in_if.sink   stream,
	abp_res_if.source result
);

	// stage 1: captured input byte
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// stage 2: result register
	logic              valid_s2;
	abp_pkg::abp_res_t res_s2;

	// parse state
	abp_pkg::abp_state_t st_q;
	abp_pkg::abp_state_t st_nxt;
	abp_pkg::abp_res_t   res_nxt;

	logic advance;
	logic take_in;

	// stage 1 moves into stage 2 when the result slot is empty or draining
	assign advance = valid_s1 && (!valid_s2 || result.ready);
	assign stream.ready = !valid_s1 || advance;
	assign take_in = stream.valid && stream.ready;

	abp_step u_step (
		.cur           (st_q),
		.data_byte     (byte_s1),
		.end_of_record (last_s1),
		.nxt           (st_nxt),
		.res           (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			st_q <= '0;
		end else begin
			if (stream.ready) valid_s1 <= stream.valid;
			if (advance) begin
				valid_s2 <= 1'b1;
				st_q <= st_nxt;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= stream.data_byte;
			last_s1 <= stream.end_of_record;
		end
		if (advance) res_s2 <= res_nxt;
	end

	assign result.valid       = valid_s2;
	assign result.field_kind  = res_s2.field_kind;
	assign result.field_value = res_s2.field_value;
	assign result.value_valid = res_s2.value_valid;
	assign result.line_index  = res_s2.line_index;
	assign result.dir_index   = res_s2.dir_index;
	assign result.item_index  = res_s2.item_index;
	assign result.status      = res_s2.status;
	assign result.final_res   = res_s2.final_res;

	// an end-marked byte always leaves the parser waiting for a version byte
	`ABP_ASSERT(a_end_resets, advance && last_s1 |=> st_q.phase == abp_pkg::PH_VER, "end mark did not restart parse")
	// an accepted record that is not yet ended parks in the done phase
	`ABP_ASSERT(a_accept_done, advance && !last_s1 && st_nxt.outcome == abp_pkg::ST_ACCEPT |=> st_q.phase == abp_pkg::PH_DONE, "accepted record not in done phase")
	// an incomplete value reads as zero
	`ABP_ASSERT(a_value_zero, valid_s2 && !res_s2.value_valid |-> res_s2.field_value == 32'd0, "partial value not zero")

endmodule

// ----- rtl/abp_step.sv -----
// Next-state and result logic for one record byte.
module abp_step (
	input  abp_pkg::abp_state_t cur,
	input  logic [7:0]          data_byte,
	input  logic                end_of_record,
	output abp_pkg::abp_state_t nxt,
	output abp_pkg::abp_res_t   res
);

	function automatic logic [7:0] clamp8(input logic [7:0] v, input logic [7:0] lim);
		return (v > lim) ? lim : v;
	endfunction

	function automatic abp_pkg::abp_state_t start_line(input abp_pkg::abp_state_t s);
		abp_pkg::abp_state_t o;
		o = s;
		o.phase = abp_pkg::PH_LABEL;
		o.field_position = '0;
		o.dir_count = '0;
		return o;
	endfunction

	function automatic abp_pkg::abp_state_t end_line(input abp_pkg::abp_state_t s);
		abp_pkg::abp_state_t o;
		o = s;
		o.line_count = s.line_count + 4'd1;
		if (o.line_count >= s.line_total) begin
			o.phase = abp_pkg::PH_DONE;
			o.outcome = abp_pkg::ST_ACCEPT;
		end else begin
			o = start_line(o);
		end
		return o;
	endfunction

	function automatic abp_pkg::abp_state_t start_dir(input abp_pkg::abp_state_t s);
		abp_pkg::abp_state_t o;
		o = s;
		o.phase = abp_pkg::PH_DEST;
		o.field_position = '0;
		return o;
	endfunction

	function automatic abp_pkg::abp_state_t end_dir(input abp_pkg::abp_state_t s);
		abp_pkg::abp_state_t o;
		o = s;
		o.dir_count = s.dir_count + 3'd1;
		if (o.dir_count >= s.dir_total) o = end_line(o);
		else o = start_dir(o);
		return o;
	endfunction

	function automatic abp_pkg::abp_state_t after_dir_count(input abp_pkg::abp_state_t s);
		abp_pkg::abp_state_t o;
		o = s;
		if (s.dir_total == 3'd0) begin
			if (s.record_version >= abp_pkg::VER_NOTICE) o.phase = abp_pkg::PH_NLEN;
			else o = end_line(o);
		end else begin
			o.dir_count = '0;
			o = start_dir(o);
		end
		return o;
	endfunction

	function automatic abp_pkg::abp_state_t after_deltas(input abp_pkg::abp_state_t s);
		abp_pkg::abp_state_t o;
		o = s;
		if (s.record_version >= abp_pkg::VER_EXPRESS) o.phase = abp_pkg::PH_EXP;
		else o = end_dir(o);
		return o;
	endfunction

	logic [6:0] fp_inc;
	logic [7:0] clamped;
	logic [4:0] shamt;

	assign fp_inc = cur.field_position + 7'd1;
	assign shamt  = {cur.field_position[1:0], 3'b000};

	always_comb begin
		nxt = cur;
		clamped = '0;
		res = '0;
		res.field_kind = (cur.phase > abp_pkg::PH_REJECT) ? abp_pkg::PH_REJECT : cur.phase;
		res.line_index = cur.line_count[2:0];
		res.dir_index  = cur.dir_count[1:0];

		if (cur.byte_total < abp_pkg::BYTE_SAT) nxt.byte_total = cur.byte_total + 7'd1;

		unique case (cur.phase)
			abp_pkg::PH_VER: begin
				res.field_value = {24'd0, data_byte};
				res.value_valid = 1'b1;
				if (data_byte < abp_pkg::VER_MIN || data_byte > abp_pkg::VER_MAX) begin
					nxt.outcome = abp_pkg::ST_REJECT;
					nxt.phase = abp_pkg::PH_REJECT;
				end else begin
					nxt.record_version = data_byte[3:0];
					nxt.phase = abp_pkg::PH_EPOCH;
					nxt.field_position = '0;
					nxt.value_accumulator = '0;
				end
			end
			abp_pkg::PH_EPOCH: begin
				res.item_index = cur.field_position;
				nxt.value_accumulator = cur.value_accumulator | ({24'd0, data_byte} << shamt);
				nxt.field_position = fp_inc;
				if (fp_inc >= abp_pkg::EPOCH_LEN) begin
					res.field_value = nxt.value_accumulator;
					res.value_valid = 1'b1;
					nxt.phase = abp_pkg::PH_STATION;
					nxt.field_position = '0;
				end
			end
			abp_pkg::PH_STATION: begin
				res.item_index = cur.field_position;
				res.field_value = {24'd0, data_byte};
				res.value_valid = 1'b1;
				nxt.field_position = fp_inc;
				if (fp_inc >= abp_pkg::STATION_LEN) begin
					nxt.phase = abp_pkg::PH_ID;
					nxt.field_position = '0;
					nxt.field_length = (cur.record_version >= abp_pkg::VER_LONG_ID) ?
						abp_pkg::ID_LONG : abp_pkg::ID_SHORT;
				end
			end
			abp_pkg::PH_ID: begin
				res.item_index = cur.field_position;
				res.field_value = {24'd0, data_byte};
				res.value_valid = 1'b1;
				nxt.field_position = fp_inc;
				if (fp_inc >= cur.field_length) nxt.phase = abp_pkg::PH_NLINES;
			end
			abp_pkg::PH_NLINES: begin
				clamped = clamp8(data_byte, abp_pkg::LINE_LIMIT);
				res.field_value = {24'd0, clamped};
				res.value_valid = 1'b1;
				nxt.line_total = clamped[3:0];
				nxt.line_count = '0;
				if (clamped == 8'd0) begin
					nxt.phase = abp_pkg::PH_DONE;
					nxt.outcome = abp_pkg::ST_ACCEPT;
				end else begin
					nxt = start_line(nxt);
				end
			end
			abp_pkg::PH_LABEL: begin
				res.item_index = cur.field_position;
				res.field_value = {24'd0, data_byte};
				res.value_valid = 1'b1;
				nxt.field_position = fp_inc;
				if (fp_inc >= abp_pkg::LABEL_LEN) nxt.phase = abp_pkg::PH_RED;
			end
			abp_pkg::PH_RED: begin
				res.field_value = {24'd0, data_byte};
				res.value_valid = 1'b1;
				nxt.phase = abp_pkg::PH_GREEN;
			end
			abp_pkg::PH_GREEN: begin
				res.field_value = {24'd0, data_byte};
				res.value_valid = 1'b1;
				nxt.phase = abp_pkg::PH_BLUE;
			end
			abp_pkg::PH_BLUE: begin
				res.field_value = {24'd0, data_byte};
				res.value_valid = 1'b1;
				nxt.phase = abp_pkg::PH_NDIRS;
			end
			abp_pkg::PH_NDIRS: begin
				clamped = clamp8(data_byte, abp_pkg::DIR_LIMIT);
				res.field_value = {24'd0, clamped};
				res.value_valid = 1'b1;
				nxt.dir_total = clamped[2:0];
				if (cur.record_version >= abp_pkg::VER_SCHED) nxt.phase = abp_pkg::PH_SCHED;
				else nxt = after_dir_count(nxt);
			end
			abp_pkg::PH_SCHED: begin
				res.field_value = {24'd0, data_byte};
				res.value_valid = 1'b1;
				nxt = after_dir_count(nxt);
			end
			abp_pkg::PH_NLEN: begin
				clamped = clamp8(data_byte, abp_pkg::NOTICE_MAX);
				res.field_value = {24'd0, clamped};
				res.value_valid = 1'b1;
				if (clamped == 8'd0) begin
					nxt = end_line(nxt);
				end else begin
					nxt.field_length = clamped[6:0];
					nxt.field_position = '0;
					nxt.phase = abp_pkg::PH_NOTICE;
				end
			end
			abp_pkg::PH_NOTICE: begin
				res.item_index = cur.field_position;
				res.field_value = {24'd0, data_byte};
				res.value_valid = 1'b1;
				nxt.field_position = fp_inc;
				if (fp_inc >= cur.field_length) nxt = end_line(nxt);
			end
			abp_pkg::PH_DEST: begin
				res.item_index = cur.field_position;
				res.field_value = {24'd0, data_byte};
				res.value_valid = 1'b1;
				nxt.field_position = fp_inc;
				if (fp_inc >= abp_pkg::DEST_LEN) begin
					nxt.field_position = '0;
					nxt.phase = (cur.record_version >= abp_pkg::VER_DLABEL) ?
						abp_pkg::PH_DLABEL : abp_pkg::PH_LEGACY;
				end
			end
			abp_pkg::PH_DLABEL: begin
				res.item_index = cur.field_position;
				res.field_value = {24'd0, data_byte};
				res.value_valid = 1'b1;
				nxt.field_position = fp_inc;
				if (fp_inc >= abp_pkg::DLABEL_LEN) nxt.phase = abp_pkg::PH_NARR;
			end
			abp_pkg::PH_LEGACY: begin
				clamped = clamp8(data_byte, abp_pkg::LEGACY_MAX);
				res.field_value = {24'd0, clamped};
				res.value_valid = 1'b1;
				nxt.phase = abp_pkg::PH_NARR;
			end
			abp_pkg::PH_NARR: begin
				clamped = clamp8(data_byte, abp_pkg::ARRIVAL_LIMIT);
				res.field_value = {24'd0, clamped};
				res.value_valid = 1'b1;
				nxt.arrival_total = clamped[3:0];
				nxt.arrival_count = '0;
				nxt.field_position = '0;
				if (clamped == 8'd0) nxt = after_deltas(nxt);
				else nxt.phase = abp_pkg::PH_DELTA;
			end
			abp_pkg::PH_DELTA: begin
				res.item_index = {3'd0, cur.arrival_count};
				if (cur.field_position == 7'd0) begin
					// low byte first, held until the high byte arrives
					nxt.value_accumulator = {24'd0, data_byte};
					nxt.field_position = 7'd1;
				end else begin
					res.field_value = {16'd0, data_byte, cur.value_accumulator[7:0]};
					res.value_valid = 1'b1;
					nxt.field_position = '0;
					nxt.arrival_count = cur.arrival_count + 4'd1;
					if (nxt.arrival_count >= cur.arrival_total) nxt = after_deltas(nxt);
				end
			end
			abp_pkg::PH_EXP: begin
				res.field_value = {24'd0, data_byte};
				res.value_valid = 1'b1;
				nxt = end_dir(nxt);
			end
			abp_pkg::PH_DONE: begin
				res.field_value = {24'd0, data_byte};
				res.value_valid = 1'b1;
				res.line_index = '0;
				res.dir_index = '0;
			end
			default: begin
				res.line_index = '0;
				res.dir_index = '0;
			end
		endcase

		if (end_of_record) begin
			if (nxt.outcome != abp_pkg::ST_REJECT &&
			    (nxt.outcome == abp_pkg::ST_PARSING || nxt.byte_total < abp_pkg::MIN_RECORD))
				nxt.outcome = abp_pkg::ST_REJECT;
			res.final_res = 1'b1;
		end
		res.status = nxt.outcome;

		// end mark: back to the version byte of a new record
		if (end_of_record) begin
			nxt = '0;
			nxt.phase = abp_pkg::PH_VER;
			nxt.outcome = abp_pkg::ST_PARSING;
		end
	end

endmodule
